/* rtl/button_debounce_confirm_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce block
// Wraps concurrent assertions so that a build can leave them out.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_CONFIRM_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_CONFIRM_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define BDC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define BDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BDC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define BDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/bdc_pkg.sv */
// ----------------------------------------------------------------------------
// Button debounce package
// Types, codes and reset values shared by the debounce block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

   // Field and register widths
   localparam int unsigned IntervalWidth = 16;
   localparam int unsigned CountWidth    = 8;
   localparam int unsigned CsrAddrWidth  = 3;
   localparam int unsigned CsrDataWidth  = 32;
   localparam int unsigned TdataWidth    = 8;

   // Register reset values
   localparam logic [IntervalWidth-1:0] IntervalReset = 16'd10;
   localparam logic [CountWidth-1:0]    CountReset    = 8'd3;

   // Register indexes, taken from address bit 2
   localparam logic CSR_IDX_INTERVAL = 1'b0;
   localparam logic CSR_IDX_COUNT    = 1'b1;

   // Transaction kinds carried in tuser
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_EDGE = 1'b1;

   // Confirmation phase
   typedef enum logic [1:0] {
      PHASE_IDLE     = 2'd0,
      PHASE_WANT_ON  = 2'd1,
      PHASE_WANT_OFF = 2'd2
   } phase_type;

endpackage : bdc_pkg

`default_nettype wire

/* rtl/button_debounce_confirm_top.sv */
// ----------------------------------------------------------------------------
// Button debounce with repeated-sample confirmation
// A result is registered and appears in the cycle after its request transaction.
// Throughput: one transaction per cycle; the single-pass state update sets it.
// A result waiting on rsp_tready holds req_tready low until it is taken.
// Reset (synchronous): idle, disarmed, LED off, interval 10, count 3.
// ----------------------------------------------------------------------------
`default_nettype none
`include "button_debounce_confirm_top_assert.svh"

module button_debounce_confirm_top
   import bdc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [TdataWidth-1:0]   req_tdata,   // [0] pin_level, [7:1] zero
   input  wire logic                    req_tuser,   // [0] op
   // result channel
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [TdataWidth-1:0]        rsp_tdata,   // [0] led_on, [1] armed, [7:2] zero
   // configuration port
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0]      csr_prdata,
   output logic                         csr_pready
);

   // Configuration registers
   logic [IntervalWidth-1:0] interval_ff;
   logic [CountWidth-1:0]    count_ff;
   logic                     csr_write;

   // Debounce state
   phase_type                phase_ff, phase_in;
   logic [IntervalWidth-1:0] tick_ff, tick_in, tick_inc;
   logic [CountWidth-1:0]    samp_ff, samp_in, samp_inc;
   logic                     conf_ff, conf_in;
   logic                     pend_ff, pend_in;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [TdataWidth-1:0]    rsp_data_ff, rsp_data_in;

   logic                     req_accept;
   logic                     pressed;

   // --------------------------------------------------------------------
   // Configuration port
   // --------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= IntervalReset;
         count_ff    <= CountReset;
      end else if (csr_write) begin
         case (csr_paddr[2])
            CSR_IDX_INTERVAL: interval_ff <= csr_pwdata[IntervalWidth-1:0];
            CSR_IDX_COUNT:    count_ff    <= csr_pwdata[CountWidth-1:0];
            default:          ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_INTERVAL: csr_prdata = {{(CsrDataWidth-IntervalWidth){1'b0}}, interval_ff};
         CSR_IDX_COUNT:    csr_prdata = {{(CsrDataWidth-CountWidth){1'b0}}, count_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // --------------------------------------------------------------------
   // Handshake
   // --------------------------------------------------------------------
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;
   assign pressed    = ~req_tdata[0];

   assign tick_inc = tick_ff + 1'b1;
   assign samp_inc = samp_ff + 1'b1;

   // --------------------------------------------------------------------
   // Next state
   // --------------------------------------------------------------------
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      samp_in  = samp_ff;
      conf_in  = conf_ff;
      pend_in  = pend_ff;
      if (req_accept) begin
         if (req_tuser == OP_EDGE) begin
            pend_in = 1'b1;
         end else if (pend_ff) begin
            case (phase_ff)
               PHASE_WANT_ON, PHASE_WANT_OFF: begin
                  // advance the interval timer, sample when it expires
                  tick_in = tick_inc;
                  if (tick_inc >= interval_ff) begin
                     tick_in = '0;
                     samp_in = samp_inc;
                     if (pressed == (phase_ff == PHASE_WANT_ON)) begin
                        if (samp_inc >= count_ff) begin
                           conf_in  = (phase_ff == PHASE_WANT_ON);
                           samp_in  = '0;
                           phase_in = PHASE_IDLE;
                        end
                     end else begin
                        // disagreeing sample: drop the phase
                        samp_in  = '0;
                        phase_in = PHASE_IDLE;
                     end
                  end
               end
               default: begin
                  // idle: start a phase toward the other state, else disarm
                  if (pressed && !conf_ff) begin
                     phase_in = PHASE_WANT_ON;
                     tick_in  = '0;
                  end else if (!pressed && conf_ff) begin
                     phase_in = PHASE_WANT_OFF;
                     tick_in  = '0;
                  end else begin
                     phase_in = PHASE_IDLE;
                     pend_in  = 1'b0;
                  end
               end
            endcase
         end
      end
   end

   // --------------------------------------------------------------------
   // Outputs
   // --------------------------------------------------------------------
   always_comb begin
      rsp_data_in  = {{(TdataWidth-2){1'b0}}, pend_in, conf_in};
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Hold the state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         tick_ff      <= '0;
         samp_ff      <= '0;
         conf_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         samp_ff      <= samp_in;
         conf_ff      <= conf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result on each accepted transaction
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // --------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------
   `BDC_ASSERT_IMP(a_phase_needs_armed, clock, reset, phase_ff != PHASE_IDLE,
      pend_ff, "confirm phase while disarmed")
   `BDC_ASSERT_IMP(a_samples_only_in_phase, clock, reset, samp_ff != '0,
      phase_ff != PHASE_IDLE, "sample count left over in idle")
   `BDC_ASSERT_NEXT(a_result_follows, clock, reset, req_accept, rsp_valid_ff,
      "no result after request transaction")
   `BDC_ASSERT_IMP(a_led_moves_on_request, clock, reset, !$stable(conf_ff),
      $past(req_accept), "LED state changed without a transaction")

endmodule : button_debounce_confirm_top

`default_nettype wire

/* tb/button_debounce_confirm_top_test.sv */
// ----------------------------------------------------------------------------
// Button debounce block testbench
// Drives tick and edge transactions through the request stream with random
// gaps and stalls. A shadow of the debounce state machine predicts the LED and
// armed flags for each transaction, and the result stream is checked against
// it. Register writes happen between batches, once the streams have drained,
// and sweep the interval and count settings.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_confirm_top_test;
   import bdc_pkg::*;

   typedef struct packed {
      logic op;
      logic pin;
   } button_event_type;

   typedef struct packed {
      logic led_on;
      logic armed;
   } lamp_state_type;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [TdataWidth-1:0]   req_tdata   = '0;   // [0] pin_level, [7:1] zero
   logic                    req_tuser   = OP_TICK; // [0] op
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [TdataWidth-1:0]   rsp_tdata;          // [0] led_on, [1] armed, [7:2] zero
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   // Pending stimulus and expected results
   button_event_type button_events[$];
   lamp_state_type   lamp_due[$];

   // Shadow of the debounce state and its registers
   phase_type              dbc_phase    = PHASE_IDLE;
   logic [IntervalWidth-1:0] dbc_ticks  = '0;
   logic [CountWidth-1:0]  dbc_samples  = '0;
   logic                   dbc_led      = 1'b0;
   logic                   dbc_armed    = 1'b0;
   logic [IntervalWidth-1:0] dbc_interval = IntervalReset;
   logic [CountWidth-1:0]  dbc_count    = CountReset;

   int               mismatches = 0;
   int               req_wait   = 0;
   int               req_burst  = 0;
   int               rsp_wait   = 0;
   int               rsp_burst  = 0;
   button_event_type next_event;
   lamp_state_type   due_now;

   button_debounce_confirm_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Generate the clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (mismatches < 40) begin
         $display("ERROR at %0t: %s", $realtime, what);
      end
      mismatches++;
   endtask

   // Draw a random wait, with occasional stretches of no waiting
   function automatic int draw_wait(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   // Advance the confirm phase by one tick
   task automatic sample_step(input logic agrees, input logic target);
      dbc_ticks = dbc_ticks + 1'b1;
      if (dbc_ticks >= dbc_interval) begin
         dbc_ticks   = '0;
         dbc_samples = dbc_samples + 1'b1;
         if (!agrees) begin
            dbc_samples = '0;
            dbc_phase   = PHASE_IDLE;
         end else if (dbc_samples >= dbc_count) begin
            dbc_led     = target;
            dbc_samples = '0;
            dbc_phase   = PHASE_IDLE;
         end
      end
   endtask

   // Update the shadow state for one transaction and queue the expected flags
   task automatic debounce_predict(input logic op, input logic pin);
      logic           pressed;
      lamp_state_type res;
      pressed = (pin == 1'b0);
      if (op == OP_EDGE) begin
         dbc_armed = 1'b1;
      end else if (dbc_armed) begin
         case (dbc_phase)
            PHASE_WANT_ON:  sample_step(pressed, 1'b1);
            PHASE_WANT_OFF: sample_step(!pressed, 1'b0);
            default: begin
               if (pressed && !dbc_led) begin
                  dbc_phase = PHASE_WANT_ON;
                  dbc_ticks = '0;
               end else if (!pressed && dbc_led) begin
                  dbc_phase = PHASE_WANT_OFF;
                  dbc_ticks = '0;
               end else begin
                  dbc_phase = PHASE_IDLE;
                  dbc_armed = 1'b0;
               end
            end
         endcase
      end
      res.led_on = dbc_led;
      res.armed  = dbc_armed;
      lamp_due.push_back(res);
   endtask

   // Request driver: predict on each accepted transaction, then load the next
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            debounce_predict(req_tuser, req_tdata[0]);
            req_wait = draw_wait(req_burst);
         end
         if (!req_tvalid || req_tready) begin
            if (req_wait > 0) begin
               req_wait--;
               req_tvalid <= 1'b0;
            end else if (button_events.size() != 0) begin
               next_event = button_events.pop_front();
               req_tuser  <= next_event.op;
               req_tdata  <= {{(TdataWidth-1){1'b0}}, next_event.pin};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: check each transaction against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (lamp_due.size() == 0) begin
               report_mismatch("result arrived with nothing expected");
            end else begin
               due_now = lamp_due.pop_front();
               if (rsp_tdata[0] !== due_now.led_on)
                  report_mismatch($sformatf("led_on got %b want %b",
                                            rsp_tdata[0], due_now.led_on));
               if (rsp_tdata[1] !== due_now.armed)
                  report_mismatch($sformatf("armed got %b want %b",
                                            rsp_tdata[1], due_now.armed));
            end
            rsp_wait = draw_wait(rsp_burst);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic queue_button(input logic op, input logic pin);
      button_events.push_back({op, pin});
   endtask

   // Hold until every transaction is sent and every result is back
   task automatic wait_drain();
      do @(negedge clock);
      while (button_events.size() != 0 || req_tvalid || lamp_due.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CsrDataWidth-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == CSR_IDX_INTERVAL) dbc_interval = value[IntervalWidth-1:0];
      else                         dbc_count    = value[CountWidth-1:0];
   endtask

   task automatic csr_check(input logic idx, input logic [CsrDataWidth-1:0] want);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      if (csr_prdata !== want)
         report_mismatch($sformatf("register %0d read %0h want %0h", idx, csr_prdata, want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write both registers and read them back
   task automatic set_registers(input int interval, input int count);
      csr_write(CSR_IDX_INTERVAL, interval);
      csr_write(CSR_IDX_COUNT, count);
      csr_check(CSR_IDX_INTERVAL, {{(CsrDataWidth-IntervalWidth){1'b0}}, dbc_interval});
      csr_check(CSR_IDX_COUNT, {{(CsrDataWidth-CountWidth){1'b0}}, dbc_count});
      @(negedge clock);
   endtask

   // Queue press and release runs: an edge, some bounce, then a mostly steady
   // level sized to confirm where the budget allows, mixed with stray transactions
   task automatic queue_press_runs(input int budget);
      int   left;
      int   need;
      int   steady;
      logic level;
      left = budget;
      while (left > 0) begin
         if ($urandom_range(0, 9) < 7) begin
            level = 1'($urandom_range(0, 1));
            queue_button(OP_EDGE, 1'($urandom_range(0, 1)));
            left--;
            repeat ($urandom_range(0, 3)) begin
               queue_button(OP_TICK, 1'($urandom_range(0, 1)));
               left--;
            end
            need = (int'(dbc_interval) + 1) * ((dbc_count == 0) ? 1 : int'(dbc_count))
                   + $urandom_range(0, 3);
            steady = (need < left) ? need : left;
            if (steady < 1) steady = 1;
            repeat (steady) begin
               queue_button(OP_TICK, ($urandom_range(0, 11) == 0) ? ~level : level);
               left--;
            end
         end else begin
            queue_button(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            left--;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset values of the registers
      csr_check(CSR_IDX_INTERVAL, {{(CsrDataWidth-IntervalWidth){1'b0}}, IntervalReset});
      csr_check(CSR_IDX_COUNT, {{(CsrDataWidth-CountWidth){1'b0}}, CountReset});

      // Zero interval and zero count: unarmed ticks, disarm, flip on, abort
      set_registers(0, 0);
      queue_button(OP_TICK, 1'b0);
      queue_button(OP_TICK, 1'b1);
      queue_button(OP_EDGE, 1'b1);
      queue_button(OP_TICK, 1'b1);
      queue_button(OP_EDGE, 1'b0);
      queue_button(OP_TICK, 1'b0);
      queue_button(OP_TICK, 1'b0);
      queue_button(OP_TICK, 1'b1);
      queue_button(OP_TICK, 1'b0);
      queue_button(OP_TICK, 1'b0);
      wait_drain();

      // Release with an edge arriving mid-confirmation
      set_registers(2, 2);
      queue_button(OP_EDGE, 1'b0);
      queue_button(OP_TICK, 1'b1);
      queue_button(OP_EDGE, 1'b1);
      repeat (4) queue_button(OP_TICK, 1'b1);
      queue_button(OP_TICK, 1'b1);
      wait_drain();

      // Random runs across a sweep of settings
      set_registers(0, 1);
      queue_press_runs(90);
      wait_drain();
      set_registers(1, 2);
      queue_press_runs(90);
      wait_drain();
      set_registers(3, 3);
      queue_press_runs(90);
      wait_drain();
      set_registers(65535, 255);
      queue_press_runs(30);
      wait_drain();
      set_registers(0, 255);
      queue_press_runs(270);
      wait_drain();
      set_registers($urandom_range(0, 4), $urandom_range(0, 4));
      queue_press_runs(60);
      wait_drain();

      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule : button_debounce_confirm_top_test

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/bdc_pkg.sv
rtl/button_debounce_confirm_top.sv
tb/button_debounce_confirm_top_test.sv
